FILE: sv/kdae_pkg.sv
// Shared types, widths and codes for the key/data array engine.
package kdae_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int ACT_W   = 4;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 5;
  localparam int IDXO_W  = 4;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Width wide enough to compare an input index against the count
  localparam int POS_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH      = 4'd0,
    ACT_POP       = 4'd1,
    ACT_SHIFT     = 4'd2,
    ACT_UNSHIFT   = 4'd3,
    ACT_READ      = 4'd4,
    ACT_SET       = 4'd5,
    ACT_INSERT    = 4'd6,
    ACT_REMOVE    = 4'd7,
    ACT_FIRST     = 4'd8,
    ACT_LAST      = 4'd9,
    ACT_SEARCH_EQ = 4'd10,
    ACT_SEARCH_GE = 4'd11,
    ACT_SEARCH_GN = 4'd12,
    ACT_CLEAR     = 4'd13
  } action_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Sequencer work modes
  typedef enum logic [1:0] {
    MD_INS = 2'd0,   // move entries up, then write the new pair
    MD_DEL = 2'd1,   // fetch one entry; on a removal, move the ones above it down
    MD_EQ  = 2'd2,   // scan for an equal key
    MD_GE  = 2'd3    // scan for a key greater than or equal
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [KEY_W-1:0]  key_in;
    logic signed [DATA_W-1:0] data_in;
    logic [IDX_W-1:0]         index;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic [IDXO_W-1:0]        index_out;
    logic signed [KEY_W-1:0]  key_out;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
    logic [STAT_W-1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            entry;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

FILE: sv/kdae_store.sv
// Entry store: one write port, one read port with registered read data.
module kdae_store (
  input  logic               clk,
  input  kdae_pkg::mem_wr_t  wr,
  input  kdae_pkg::mem_rd_t  rd,
  output kdae_pkg::entry_t   rd_entry
);

  kdae_pkg::entry_t mem [kdae_pkg::CAPACITY];

  // Write and read-first registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd.en) begin
      rd_entry <= mem[rd.addr];
    end
  end

endmodule

FILE: sv/kdae_ctrl.sv
// Action decode, entry count and read-modify-write sequencer over the store.
module kdae_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  kdae_pkg::in_item_t   in_item,
  output logic                 busy,
  output logic                 res_valid,
  input  logic                 res_ready,
  output kdae_pkg::out_item_t  res_item,
  output kdae_pkg::mem_wr_t    mem_wr,
  output kdae_pkg::mem_rd_t    mem_rd,
  input  kdae_pkg::entry_t     rd_entry
);

  localparam int ADDR_W = kdae_pkg::ADDR_W;
  localparam int CNT_W  = kdae_pkg::CNT_W;
  localparam int POS_W  = kdae_pkg::POS_W;

  kdae_pkg::state_t  state_r, state_nxt;
  kdae_pkg::mode_t   mode_r, mode_nxt;
  kdae_pkg::status_t status_r, status_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic signed [kdae_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic signed [kdae_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  logic signed [kdae_pkg::DATA_W-1:0] res_data_r, res_data_nxt;

  logic acc;

  // Decode of the offered item against the current count
  logic              full, empty, closes;
  logic [POS_W-1:0]  n_pos, i_pos, dec_pos;
  logic              dec_run, dec_found;
  kdae_pkg::mode_t   dec_mode;
  kdae_pkg::status_t dec_status;
  logic [CNT_W-1:0]  dec_left, dec_cnt;
  logic [ADDR_W-1:0] dec_ptr;
  logic signed [kdae_pkg::KEY_W-1:0]  dec_key;
  logic signed [kdae_pkg::DATA_W-1:0] dec_data;

  always_comb begin
    full       = (count_r == CNT_W'(kdae_pkg::CAPACITY));
    empty      = (count_r == '0);
    n_pos      = POS_W'(count_r);
    i_pos      = POS_W'(in_item.index);
    closes     = 1'b0;
    dec_pos    = '0;
    dec_run    = 1'b0;
    dec_found  = 1'b0;
    dec_mode   = kdae_pkg::MD_INS;
    dec_status = kdae_pkg::ST_OK;
    dec_left   = '0;
    dec_cnt    = count_r;
    dec_ptr    = '0;
    dec_key    = '0;
    dec_data   = '0;
    case (in_item.action)
      kdae_pkg::ACT_PUSH, kdae_pkg::ACT_UNSHIFT, kdae_pkg::ACT_INSERT: begin
        if (in_item.action == kdae_pkg::ACT_PUSH) begin
          dec_pos = n_pos;
        end else if (in_item.action == kdae_pkg::ACT_UNSHIFT) begin
          dec_pos = '0;
        end else begin
          dec_pos = i_pos;
        end
        if (full) begin
          dec_status = kdae_pkg::ST_FULL;
          dec_pos    = '0;
        end else if (dec_pos > n_pos) begin
          dec_status = kdae_pkg::ST_RANGE;
          dec_pos    = '0;
        end else begin
          dec_run  = 1'b1;
          dec_mode = kdae_pkg::MD_INS;
          dec_left = CNT_W'(n_pos - dec_pos);
          dec_ptr  = ADDR_W'(n_pos - POS_W'(1));
          dec_cnt  = count_r + CNT_W'(1);
          dec_key  = in_item.key_in;
          dec_data = in_item.data_in;
        end
      end
      kdae_pkg::ACT_SET: begin
        if (i_pos > n_pos) begin
          dec_status = kdae_pkg::ST_RANGE;
        end else if (i_pos == n_pos && full) begin
          dec_status = kdae_pkg::ST_FULL;
        end else begin
          dec_run  = 1'b1;
          dec_mode = kdae_pkg::MD_INS;
          dec_pos  = i_pos;
          dec_cnt  = (i_pos == n_pos) ? count_r + CNT_W'(1) : count_r;
          dec_key  = in_item.key_in;
          dec_data = in_item.data_in;
        end
      end
      kdae_pkg::ACT_POP, kdae_pkg::ACT_SHIFT, kdae_pkg::ACT_READ,
      kdae_pkg::ACT_REMOVE, kdae_pkg::ACT_FIRST, kdae_pkg::ACT_LAST: begin
        closes = (in_item.action == kdae_pkg::ACT_POP) ||
                 (in_item.action == kdae_pkg::ACT_SHIFT) ||
                 (in_item.action == kdae_pkg::ACT_REMOVE);
        if (in_item.action == kdae_pkg::ACT_POP || in_item.action == kdae_pkg::ACT_LAST) begin
          dec_pos = n_pos - POS_W'(1);
        end else if (in_item.action == kdae_pkg::ACT_SHIFT ||
                     in_item.action == kdae_pkg::ACT_FIRST) begin
          dec_pos = '0;
        end else begin
          dec_pos = i_pos;
        end
        if (empty) begin
          dec_status = kdae_pkg::ST_EMPTY;
          dec_pos    = '0;
        end else if (dec_pos >= n_pos) begin
          dec_status = kdae_pkg::ST_RANGE;
          dec_pos    = '0;
        end else begin
          dec_run   = 1'b1;
          dec_mode  = kdae_pkg::MD_DEL;
          dec_found = 1'b1;
          dec_ptr   = ADDR_W'(dec_pos);
          dec_left  = closes ? CNT_W'(n_pos - dec_pos) : CNT_W'(1);
          dec_cnt   = closes ? count_r - CNT_W'(1) : count_r;
        end
      end
      kdae_pkg::ACT_SEARCH_EQ: begin
        dec_run  = 1'b1;
        dec_mode = kdae_pkg::MD_EQ;
        dec_left = count_r;
        dec_key  = in_item.key_in;
      end
      kdae_pkg::ACT_SEARCH_GE, kdae_pkg::ACT_SEARCH_GN: begin
        dec_run  = 1'b1;
        dec_mode = kdae_pkg::MD_GE;
        if (in_item.action == kdae_pkg::ACT_SEARCH_GE || empty) begin
          dec_left = count_r;
        end else begin
          dec_left = count_r - CNT_W'(1);
        end
      end
      kdae_pkg::ACT_CLEAR: begin
        dec_cnt = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: one store read issued and one earlier read consumed per cycle
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    status_nxt   = status_r;
    count_nxt    = count_r;
    left_nxt     = left_r;
    ptr_nxt      = ptr_r;
    src_nxt      = src_r;
    pos_nxt      = pos_r;
    pend_nxt     = pend_r;
    found_nxt    = found_r;
    key_nxt      = key_r;
    res_key_nxt  = res_key_r;
    res_data_nxt = res_data_r;
    acc          = 1'b0;
    mem_rd       = '0;
    mem_wr       = '0;
    mem_wr.entry = rd_entry;
    case (state_r)
      kdae_pkg::S_IDLE: begin
        if (in_valid) begin
          acc          = 1'b1;
          state_nxt    = dec_run ? kdae_pkg::S_RUN : kdae_pkg::S_DONE;
          mode_nxt     = dec_mode;
          status_nxt   = dec_status;
          count_nxt    = dec_cnt;
          left_nxt     = dec_left;
          ptr_nxt      = dec_ptr;
          pos_nxt      = ADDR_W'(dec_pos);
          pend_nxt     = 1'b0;
          found_nxt    = dec_found;
          key_nxt      = in_item.key_in;
          res_key_nxt  = dec_key;
          res_data_nxt = dec_data;
        end
      end
      kdae_pkg::S_RUN: begin
        // issue the next read
        if (left_r != '0) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = ptr_r;
          pend_nxt    = 1'b1;
          src_nxt     = ptr_r;
          ptr_nxt     = (mode_r == kdae_pkg::MD_INS) ? ptr_r - ADDR_W'(1)
                                                     : ptr_r + ADDR_W'(1);
          left_nxt    = left_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        // consume the read issued last cycle
        if (pend_r) begin
          case (mode_r)
            kdae_pkg::MD_INS: begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = src_r + ADDR_W'(1);
            end
            kdae_pkg::MD_DEL: begin
              if (src_r == pos_r) begin
                res_key_nxt  = rd_entry.key;
                res_data_nxt = rd_entry.data;
              end else begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = src_r - ADDR_W'(1);
              end
            end
            kdae_pkg::MD_EQ: begin
              if (rd_entry.key == key_r) begin
                found_nxt    = 1'b1;
                pos_nxt      = src_r;
                res_data_nxt = rd_entry.data;
                state_nxt    = kdae_pkg::S_DONE;
                pend_nxt     = 1'b0;
                left_nxt     = '0;
              end
            end
            kdae_pkg::MD_GE: begin
              if ($signed(rd_entry.key) >= $signed(key_r)) begin
                found_nxt    = 1'b1;
                pos_nxt      = src_r;
                res_key_nxt  = rd_entry.key;
                res_data_nxt = rd_entry.data;
                state_nxt    = kdae_pkg::S_DONE;
                pend_nxt     = 1'b0;
                left_nxt     = '0;
              end
            end
            default: begin
            end
          endcase
        end
        // all moves done: place the new pair for writes
        if (left_r == '0 && !pend_r) begin
          if (mode_r == kdae_pkg::MD_INS) begin
            mem_wr.en         = 1'b1;
            mem_wr.addr       = pos_r;
            mem_wr.entry.key  = res_key_r;
            mem_wr.entry.data = res_data_r;
          end
          state_nxt = kdae_pkg::S_DONE;
        end
      end
      kdae_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = kdae_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kdae_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdae_pkg::S_IDLE;
      count_r <= '0;
      left_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    status_r   <= status_nxt;
    ptr_r      <= ptr_nxt;
    src_r      <= src_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    key_r      <= key_nxt;
    res_key_r  <= res_key_nxt;
    res_data_r <= res_data_nxt;
  end

  assign busy      = (state_r != kdae_pkg::S_IDLE);
  assign res_valid = (state_r == kdae_pkg::S_DONE);

  always_comb begin
    res_item           = '0;
    res_item.found     = found_r;
    res_item.index_out = kdae_pkg::IDXO_W'(pos_r);
    res_item.key_out   = res_key_r;
    res_item.data_out  = res_data_r;
    res_item.count     = kdae_pkg::COUNT_W'(count_r);
    res_item.status    = status_r;
  end

  // Count never passes the store size
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(kdae_pkg::CAPACITY))
    else $error("entry count above capacity");

  // Moves and new pairs land only inside the live region
  a_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> (CNT_W'(mem_wr.addr) < count_r))
    else $error("store write outside live entries");

  // Reads never reach past the old end of the array
  a_rd_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd.en |-> (CNT_W'(mem_rd.addr) <= count_r))
    else $error("store read beyond old entry count");

  // Count moves only on an accepted transfer
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("entry count changed without a transfer");

  // A pending read is consumed only while running
  a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == kdae_pkg::S_RUN))
    else $error("read pending outside the run state");

endmodule

FILE: sv/key_data_array_engine.sv
// Top level of the key/data array engine: sequencer, entry store, result register.
// An item is taken when the engine is idle, even while the previous result still
// sits in the output register, and gives exactly one result. Refusals, clear and
// unused codes read no store entry. Every other action walks the entry store
// (one write port, one read port) one entry per cycle, reading at most CAPACITY
// entries (moved, fetched or compared). A search stops at its first hit. The store
// needs no clearing pass after reset; only the entry count is cleared.
module key_data_array_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kdae_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kdae_pkg::out_item_t  out_item
);

  logic                busy;
  logic                res_valid;
  logic                res_ready;
  kdae_pkg::out_item_t res_item;
  kdae_pkg::mem_wr_t   mem_wr;
  kdae_pkg::mem_rd_t   mem_rd;
  kdae_pkg::entry_t    rd_entry;

  logic                out_valid_r;
  kdae_pkg::out_item_t out_item_r;

  kdae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .rd_entry  (rd_entry)
  );

  kdae_store u_store (
    .clk      (clk),
    .wr       (mem_wr),
    .rd       (mem_rd),
    .rd_entry (rd_entry)
  );

  assign in_stall = busy;

  // Output register: loads when empty or when its transfer completes
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
